FILE: rtl/core/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	// Field widths fixed by the request and result words
	localparam int KEY_W       = 32;
	localparam int VALUE_W     = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;

	// Default table depth
	localparam int DEFAULT_CAPACITY = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_ACCESS = 2'd2;
	localparam logic [OP_W-1:0] OP_ASSIGN = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOEFFECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	// Update command from the control path to the table
	typedef struct packed {
		logic               set_valid;
		logic               clear_valid;
		logic               write_key;
		logic               write_value;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} upd_t;

	// Lookup result from the table to the control path
	typedef struct packed {
		logic               hit;
		logic               full;
		logic [VALUE_W-1:0] value;
	} look_t;

endpackage

`default_nettype wire

FILE: rtl/core/kvt_cam.sv
`default_nettype none

module kvt_cam #(
	parameter int CAPACITY = kvt_pkg::DEFAULT_CAPACITY,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [kvt_pkg::KEY_W-1:0]  key,
	output kvt_pkg::look_t                  look,
	output logic      [CAPACITY-1:0]        match,
	output logic      [CAPACITY-1:0]        free_sel,
	input  wire logic                       upd_en,
	input  wire kvt_pkg::upd_t              upd,
	input  wire logic [CAPACITY-1:0]        slot_sel,
	output logic      [CNT_W-1:0]           count_nxt
);

	logic [kvt_pkg::KEY_W-1:0]   key_q   [CAPACITY];
	logic [kvt_pkg::VALUE_W-1:0] value_q [CAPACITY];
	logic [CAPACITY-1:0]         valid_q;
	logic [CNT_W-1:0]            count_q;

	// Compare all occupied entries against the key
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key);
		end
	end

	// Select the stored value of the matching entry (keys are unique)
	always_comb begin
		look.hit   = |match;
		look.full  = &valid_q;
		look.value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			look.value = look.value | (value_q[i] & {kvt_pkg::VALUE_W{match[i]}});
		end
	end

	// Lowest free entry as a one-hot vector
	assign free_sel = ~valid_q & (valid_q + CAPACITY'(1));

	// Entry count after the pending update
	always_comb begin
		count_nxt = count_q;
		if (upd_en && upd.set_valid) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (upd_en && upd.clear_valid) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Occupancy flags and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (upd_en) begin
			count_q <= count_nxt;
			for (int i = 0; i < CAPACITY; i++) begin
				if (slot_sel[i] && upd.set_valid) begin
					valid_q[i] <= 1'b1;
				end else if (slot_sel[i] && upd.clear_valid) begin
					valid_q[i] <= 1'b0;
				end
			end
		end
	end

	// Key and value storage
	always_ff @(posedge clk) begin
		if (upd_en) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (slot_sel[i] && upd.write_key) begin
					key_q[i] <= upd.key;
				end
				if (slot_sel[i] && upd.write_value) begin
					value_q[i] <= upd.value;
				end
			end
		end
	end

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_q)) == count_q)
		else $error("entry count differs from occupied entries");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("key matches more than one entry");

	a_slot_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en && (upd.set_valid || upd.clear_valid) |-> $onehot(slot_sel))
		else $error("update targets not exactly one entry");

	a_set_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en && upd.set_valid |-> (slot_sel & valid_q) == '0)
		else $error("new pair placed on an occupied entry");

endmodule

`default_nettype wire

FILE: rtl/core/key_value_table.sv
// Flow: an accepted request word is loaded into the request register and its result word
//   into the result register. Throughput: one request per cycle while the result word is
//   taken or the result register is empty; the parallel compare of all entries and the
//   update of the table complete between the request register and the result register.
// Reset: arst_n clears the occupancy flags, the entry count and both valid flags;
//   key and value storage keep their contents and are read only when occupied.
`default_nettype none

module key_value_table #(
	parameter int CAPACITY = kvt_pkg::DEFAULT_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // lookup_key[31:0], data_value[63:32]
	input  wire logic [1:0]  s_tuser,  // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,  // read_value[31:0], entry_count[36:32], zero[39:37]
	output logic      [2:0]  m_tuser   // hit[0], status[2:1]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (CNT_W > kvt_pkg::COUNT_OUT_W) ? CNT_W : kvt_pkg::COUNT_OUT_W;

	// Request register
	logic                          valid_s1;
	logic [kvt_pkg::OP_W-1:0]      op_s1;
	logic [kvt_pkg::KEY_W-1:0]     key_s1;
	logic [kvt_pkg::VALUE_W-1:0]   data_s1;

	// Result register
	logic                          valid_s2;
	logic                          hit_s2;
	logic [kvt_pkg::VALUE_W-1:0]   value_s2;
	logic [kvt_pkg::COUNT_OUT_W-1:0] count_s2;
	logic [kvt_pkg::STATUS_W-1:0]  status_s2;

	kvt_pkg::look_t                look;
	kvt_pkg::upd_t                 upd;
	logic [CAPACITY-1:0]           match;
	logic [CAPACITY-1:0]           free_sel;
	logic [CAPACITY-1:0]           slot_sel;
	logic [CNT_W-1:0]              count_nxt;
	logic [EXT_W-1:0]              count_ext;
	logic                          advance;
	logic [kvt_pkg::VALUE_W-1:0]   rd_value;
	logic [kvt_pkg::STATUS_W-1:0]  status;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Load the request word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			key_s1  <= s_tdata[31:0];
			data_s1 <= s_tdata[63:32];
		end
	end

	kvt_cam #(
		.CAPACITY (CAPACITY)
	) u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key_s1),
		.look      (look),
		.match     (match),
		.free_sel  (free_sel),
		.upd_en    (advance),
		.upd       (upd),
		.slot_sel  (slot_sel),
		.count_nxt (count_nxt)
	);

	// Decide the table update and the result of the request
	always_comb begin
		upd.set_valid   = 1'b0;
		upd.clear_valid = 1'b0;
		upd.write_key   = 1'b0;
		upd.write_value = 1'b0;
		upd.key         = key_s1;
		upd.value       = data_s1;
		rd_value        = '0;
		status          = kvt_pkg::ST_DONE;
		slot_sel        = look.hit ? match : free_sel;
		if (op_s1 == kvt_pkg::OP_DELETE) begin
			if (look.hit) begin
				upd.clear_valid = 1'b1;
			end else begin
				status = kvt_pkg::ST_NOEFFECT;
			end
		end else if (look.hit) begin
			rd_value = look.value;
			if (op_s1 == kvt_pkg::OP_INSERT) begin
				status = kvt_pkg::ST_NOEFFECT;
			end else if (op_s1 == kvt_pkg::OP_ASSIGN) begin
				upd.write_value = 1'b1;
				rd_value        = data_s1;
			end
		end else if (look.full) begin
			status = kvt_pkg::ST_FULL;
		end else begin
			// Create the pair; access starts it at zero
			upd.set_valid   = 1'b1;
			upd.write_key   = 1'b1;
			upd.write_value = 1'b1;
			if (op_s1 == kvt_pkg::OP_ACCESS) begin
				upd.value = '0;
			end
			rd_value = upd.value;
		end
	end

	assign count_ext = EXT_W'(count_nxt);

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2    <= look.hit;
			value_s2  <= rd_value;
			count_s2  <= count_ext[kvt_pkg::COUNT_OUT_W-1:0];
			status_s2 <= status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, count_s2, value_s2};
	assign m_tuser  = {status_s2, hit_s2};

	a_full_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s2 == kvt_pkg::ST_FULL) |-> !hit_s2 && (value_s2 == '0))
		else $error("refused creation reported with a hit or a value");

	a_absent_delete_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_s2 == kvt_pkg::ST_NOEFFECT) && !hit_s2 |-> value_s2 == '0)
		else $error("absent delete reported a value");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while waiting");

endmodule

`default_nettype wire
